// ----- sv/stc_pkg.sv -----
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types, constants and helpers for the stepper command block.
// ----------------------------------------------------------------------------
package stc_pkg;

	localparam int unsigned CLOCK_HZ = 16000000;
	localparam int unsigned PRESCALE = 8;

	localparam int DIV_W = 48;

	localparam logic [16:0] RPM_CAP     = 17'd1000;
	// turn products at or above 65536 * 360 clamp the count
	localparam logic [47:0] CNT_CLAMP   = 48'd23592960;
	// ceil(2^28 / 45): exact floor division by 45 for 22-bit inputs
	localparam logic [22:0] CNT_RECIP   = 23'd5965233;
	// ceil(2^28 / 15): exact floor division by 15 for 24-bit inputs
	localparam logic [24:0] FREQ_RECIP  = 25'd17895698;
	localparam logic [47:0] DIV_CLOCK   = 48'(CLOCK_HZ);
	localparam logic [47:0] PER_SCALE   = 48'(2 * PRESCALE);
	localparam logic [15:0] MSTEP_RST   = 16'd200;
	localparam logic [30:0] BUDGET_RST  = 31'd30000;
	localparam logic [30:0] BUDGET_MAX  = 31'h7FFF_FFFF;
	localparam logic signed [33:0] SAVE_DRIFT = 34'sd500;

	typedef enum logic [1:0] {
		KIND_SPEED = 2'd0,
		KIND_TURN  = 2'd1,
		KIND_POLL  = 2'd2,
		KIND_STOP  = 2'd3
	} kind_t;

	typedef enum logic {
		CFG_MICROSTEPS = 1'b0,
		CFG_BUDGET     = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CNT,
		ST_FREQ,
		ST_PER,
		ST_EXEC
	} back_st_t;

	// classified request as it travels through the queue
	typedef struct packed {
		kind_t        kind;
		logic         rpm_pos;
		logic         rpm_neg;
		logic [16:0]  mag;
		logic [25:0]  spd_prod;
		logic [47:0]  cnt_prod;
		logic [15:0]  sample;
	} cmd_t;

	// quotient minus one, saturated to 16 bits; zero gives all ones
	function automatic logic [15:0] sat_m1(input logic [47:0] q);
		logic [15:0] r;
		if (q == 48'd0 || q >= 48'd65536) begin
			r = 16'hFFFF;
		end else begin
			r = q[15:0] - 16'd1;
		end
		return r;
	endfunction

endpackage

// ----- sv/stc_cmd_if.sv -----
// ----------------------------------------------------------------------------
// stc_cmd_if
// Command request channel.
// ----------------------------------------------------------------------------
interface stc_cmd_if import stc_pkg::*; ();
	logic               valid;
	logic               ready;
	kind_t              kind;
	logic signed [15:0] rpm;
	logic signed [31:0] angle_deg;
	logic [15:0]        count_sample;

	modport source (output valid, kind, rpm, angle_deg, count_sample, input ready);
	modport sink (input valid, kind, rpm, angle_deg, count_sample, output ready);
endinterface

// ----- sv/stc_res_if.sv -----
// ----------------------------------------------------------------------------
// stc_res_if
// Result request channel.
// ----------------------------------------------------------------------------
interface stc_res_if import stc_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [15:0] step_compare;
	logic        step_active;
	logic        direction_cw;
	logic        driver_enable;
	logic [15:0] target_compare;
	logic        counter_clear;
	logic [30:0] budget_left;
	logic        tripped;
	logic        save_request;

	modport source (output valid, step_compare, step_active, direction_cw, driver_enable,
		target_compare, counter_clear, budget_left, tripped, save_request, input ready);
	modport sink (input valid, step_compare, step_active, direction_cw, driver_enable,
		target_compare, counter_clear, budget_left, tripped, save_request, output ready);
endinterface

// ----- sv/stc_cfg_if.sv -----
// ----------------------------------------------------------------------------
// stc_cfg_if
// Configuration register write channel.
// ----------------------------------------------------------------------------
interface stc_cfg_if import stc_pkg::*; ();
	logic        valid;
	logic        ready;
	cfg_idx_t    index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/stepper_command_travel_limit.sv -----
// ----------------------------------------------------------------------------
// stepper_command_travel_limit
// Stepper command block with step rate, turn count and travel budget limit.
// ----------------------------------------------------------------------------
// flow: poll, stop and zero speed go idle, exec; speed goes idle, rate, then the
//   serial step-period divider and exec; turn adds count; zero rate skips divider
// throughput: one request at a time in the back end, the next starts in the cycle
//   after a result is written; the 2-entry queue lets the front accept meanwhile
// reset: motor state and queue cleared, budget 30000, microsteps 200
module stepper_command_travel_limit import stc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	stc_cmd_if.sink   cmd,
	stc_res_if.source res,
	stc_cfg_if.sink   cfg
);
	logic        push;
	logic        pop;
	logic        q_full;
	logic        q_valid;
	cmd_t        q_wdata;
	cmd_t        q_rdata;
	logic [15:0] microsteps;

	stc_front u_front (
		.cmd        (cmd),
		.microsteps (microsteps),
		.q_full     (q_full),
		.push       (push),
		.wdata      (q_wdata)
	);

	stc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_wdata),
		.full   (q_full),
		.valid  (q_valid),
		.rdata  (q_rdata),
		.pop    (pop)
	);

	stc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.res        (res),
		.q_valid    (q_valid),
		.q_data     (q_rdata),
		.q_pop      (pop),
		.microsteps (microsteps)
	);

	// queue never pushed while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_full)) else $error("queue overflow");

	// a tripped result never shows the driver enabled
	a_trip_off: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.tripped |-> !res.driver_enable) else $error("enabled while tripped");

	// stopped step output always carries a cleared compare value
	a_idle_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.step_active |-> res.step_compare == 16'd0)
		else $error("compare value while stopped");
endmodule

// ----- sv/stc_fifo.sv -----
// ----------------------------------------------------------------------------
// stc_fifo
// Two-entry queue between the command front end and the execution back end.
// ----------------------------------------------------------------------------
module stc_fifo import stc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic full,
	output logic valid,
	output cmd_t rdata,
	input  logic pop
);
	cmd_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign rdata = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ----- sv/stc_front.sv -----
// ----------------------------------------------------------------------------
// stc_front
// Accepts command requests and reduces them to magnitudes and products.
// ----------------------------------------------------------------------------
module stc_front import stc_pkg::*; (
	stc_cmd_if.sink    cmd,
	input  logic [15:0] microsteps,
	input  logic        q_full,
	output logic        push,
	output cmd_t        wdata
);
	logic signed [15:0] rpm_eff;
	logic [16:0]        rpm_ext;
	logic [16:0]        mag;
	logic [9:0]         capped;
	logic [31:0]        ang_mag;

	assign cmd.ready = ~q_full;
	assign push      = cmd.valid & ~q_full;

	// a negative turn angle reverses the speed sign
	always_comb begin
		rpm_eff = cmd.rpm;
		if (cmd.kind == KIND_TURN && cmd.angle_deg[31]) begin
			rpm_eff = 16'(-cmd.rpm);
		end
		rpm_ext = {rpm_eff[15], rpm_eff};
		mag     = rpm_ext[16] ? 17'(17'd0 - rpm_ext) : rpm_ext;
		capped  = (mag > RPM_CAP) ? RPM_CAP[9:0] : mag[9:0];
		ang_mag = cmd.angle_deg[31] ? 32'(32'd0 - cmd.angle_deg) : cmd.angle_deg;
	end

	// queue entry
	always_comb begin
		wdata.kind     = cmd.kind;
		wdata.rpm_pos  = ~rpm_eff[15] & (rpm_eff != 16'sd0);
		wdata.rpm_neg  = rpm_eff[15];
		wdata.mag      = mag;
		wdata.spd_prod = 26'(capped) * 26'(microsteps);
		wdata.cnt_prod = 48'(ang_mag) * 48'(microsteps);
		wdata.sample   = cmd.count_sample;
	end
endmodule

// ----- sv/stc_div.sv -----
// ----------------------------------------------------------------------------
// stc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stc_div import stc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quot
);
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] dvs_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   shifted;
	logic [DIV_W:0]   diff;

	assign done = done_q;
	assign quot = quo_q;

	// one trial subtraction
	always_comb begin
		shifted = {rem_q, quo_q[DIV_W-1]};
		diff    = shifted - {1'b0, dvs_q};
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[DIV_W]) begin
				rem_q <= diff[DIV_W-1:0];
			end else begin
				rem_q <= shifted[DIV_W-1:0];
			end
			quo_q <= {quo_q[DIV_W-2:0], ~diff[DIV_W]};
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(DIV_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

// ----- sv/stc_back.sv -----
// ----------------------------------------------------------------------------
// stc_back
// Executes queued requests: divisions, motor state, travel budget, results.
// ----------------------------------------------------------------------------
module stc_back import stc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	stc_cfg_if.sink     cfg,
	stc_res_if.source   res,
	input  logic        q_valid,
	input  cmd_t        q_data,
	output logic        q_pop,
	output logic [15:0] microsteps
);
	back_st_t    st_q, st_d;
	cmd_t        cmd_q;
	logic        exec;
	logic        div_start;
	logic [47:0] div_dvd;
	logic [47:0] div_dvs;
	logic        div_done;
	logic [47:0] div_quo;
	logic [15:0] cnt_cmp_q;
	logic [15:0] spd_cmp_q;

	logic [21:0] cnt_in;
	logic [44:0] cnt_mul;
	logic [16:0] cnt_val;
	logic [15:0] cnt_cmp;
	logic [23:0] f_in;
	logic [48:0] f_mul;
	logic [20:0] f_val;

	logic [15:0] ms_q;
	logic        dir_q, run_q, pulse_q, limit_q, zsaved_q;
	logic [15:0] cmp_q, angle_q, prev_q;
	logic [30:0] budget_q, saved_q;

	logic        dir_d, run_d, pulse_d, limit_d, zsaved_d, clear_d, save_d;
	logic [15:0] cmp_d, angle_d, prev_d;
	logic [30:0] budget_d, saved_d;
	logic signed [33:0] b;
	logic signed [33:0] drift;
	logic [15:0] delta;

	assign microsteps = ms_q;
	assign cfg.ready  = 1'b1;

	stc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quot     (div_quo)
	);

	// turn count (product / 360) and step rate (product / 60) by reciprocal
	always_comb begin
		cnt_in  = cmd_q.cnt_prod[24:3];
		cnt_mul = 45'(cnt_in) * 45'(CNT_RECIP);
		cnt_val = cnt_mul[44:28];
		if (cmd_q.cnt_prod >= CNT_CLAMP) begin
			cnt_cmp = 16'hFFFF;
		end else begin
			cnt_cmp = sat_m1(48'(cnt_val));
		end
		f_in  = cmd_q.spd_prod[25:2];
		f_mul = 49'(f_in) * 49'(FREQ_RECIP);
		f_val = f_mul[48:28];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// sequencer: turn count, step rate, period division, execution
	always_comb begin
		st_d      = st_q;
		q_pop     = 1'b0;
		exec      = 1'b0;
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		case (st_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_data.kind == KIND_TURN) begin
						st_d = ST_CNT;
					end else if (q_data.kind == KIND_SPEED && q_data.mag != 17'd0) begin
						st_d = ST_FREQ;
					end else begin
						st_d = ST_EXEC;
					end
				end
			end
			ST_CNT: begin
				if (cmd_q.mag != 17'd0) begin
					st_d = ST_FREQ;
				end else begin
					st_d = ST_EXEC;
				end
			end
			ST_FREQ: begin
				if (f_val == 21'd0) begin
					st_d = ST_EXEC;
				end else begin
					div_start = 1'b1;
					div_dvd   = DIV_CLOCK;
					div_dvs   = 48'(f_val) * PER_SCALE;
					st_d      = ST_PER;
				end
			end
			ST_PER: begin
				if (div_done) begin
					st_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!res.valid || res.ready) begin
					exec = 1'b1;
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	// request and quotient holding registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_data;
		end
		if (st_q == ST_CNT) begin
			cnt_cmp_q <= cnt_cmp;
		end
		if (st_q == ST_FREQ && f_val == 21'd0) begin
			spd_cmp_q <= 16'hFFFF;
		end
		if (st_q == ST_PER && div_done) begin
			spd_cmp_q <= sat_m1(div_quo);
		end
	end

	// next motor and budget state for the held request
	always_comb begin
		dir_d    = dir_q;
		run_d    = run_q;
		pulse_d  = pulse_q;
		limit_d  = limit_q;
		zsaved_d = zsaved_q;
		cmp_d    = cmp_q;
		angle_d  = angle_q;
		prev_d   = prev_q;
		budget_d = budget_q;
		saved_d  = saved_q;
		clear_d  = 1'b0;
		save_d   = 1'b0;
		b        = 34'(budget_q);
		drift    = '0;
		delta    = cmd_q.sample - prev_q;
		case (cmd_q.kind)
			KIND_SPEED, KIND_TURN: begin
				if (cmd_q.kind == KIND_TURN) begin
					angle_d = cnt_cmp_q;
					clear_d = 1'b1;
				end
				if (cmd_q.rpm_pos) begin
					dir_d = 1'b1;
				end else if (cmd_q.rpm_neg) begin
					dir_d = 1'b0;
				end
				if (cmd_q.mag == 17'd0) begin
					pulse_d = 1'b0;
					cmp_d   = 16'd0;
				end else begin
					cmp_d   = spd_cmp_q;
					pulse_d = 1'b1;
					if (!run_q && !limit_q) begin
						run_d = 1'b1;
					end
				end
			end
			KIND_POLL: begin
				// move the budget by the counter delta
				if (budget_q != 31'd0 || !dir_q) begin
					prev_d  = cmd_q.sample;
					limit_d = 1'b0;
					if (dir_q) begin
						b = b - 34'(delta);
					end else begin
						b = b + 34'(delta);
					end
					if (b > $signed(34'(BUDGET_MAX))) begin
						b = 34'(BUDGET_MAX);
					end
				end
				// trip at zero or below
				if (b <= 34'sd0) begin
					pulse_d = 1'b0;
					cmp_d   = 16'd0;
					angle_d = 16'd0;
					run_d   = 1'b0;
					prev_d  = 16'd0;
					dir_d   = 1'b0;
					clear_d = 1'b1;
					b       = '0;
					limit_d = 1'b1;
				end
				budget_d = b[30:0];
				// save check
				drift = b - 34'(saved_q);
				if (drift > SAVE_DRIFT || drift < -SAVE_DRIFT) begin
					save_d  = 1'b1;
					saved_d = b[30:0];
				end else if (b == 34'sd0 && !zsaved_q) begin
					save_d   = 1'b1;
					saved_d  = 31'd0;
					zsaved_d = 1'b1;
				end
			end
			default: begin
				pulse_d = 1'b0;
				cmp_d   = 16'd0;
				angle_d = 16'd0;
				run_d   = 1'b0;
				prev_d  = 16'd0;
				dir_d   = 1'b0;
				clear_d = 1'b1;
			end
		endcase
	end

	// architectural state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q     <= MSTEP_RST;
			dir_q    <= 1'b0;
			run_q    <= 1'b0;
			pulse_q  <= 1'b0;
			limit_q  <= 1'b0;
			zsaved_q <= 1'b0;
			cmp_q    <= 16'd0;
			angle_q  <= 16'd0;
			prev_q   <= 16'd0;
			budget_q <= BUDGET_RST;
			saved_q  <= BUDGET_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_MICROSTEPS: ms_q <= cfg.data;
				CFG_BUDGET: begin
					budget_q <= 31'(cfg.data);
					saved_q  <= 31'(cfg.data);
				end
				default: ;
			endcase
		end else if (exec) begin
			dir_q    <= dir_d;
			run_q    <= run_d;
			pulse_q  <= pulse_d;
			limit_q  <= limit_d;
			zsaved_q <= zsaved_d;
			cmp_q    <= cmp_d;
			angle_q  <= angle_d;
			prev_q   <= prev_d;
			budget_q <= budget_d;
			saved_q  <= saved_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
		end else if (exec) begin
			res.valid <= 1'b1;
		end else if (res.ready) begin
			res.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			res.step_compare   <= cmp_d;
			res.step_active    <= pulse_d;
			res.direction_cw   <= dir_d;
			res.driver_enable  <= run_d;
			res.target_compare <= angle_d;
			res.counter_clear  <= clear_d;
			res.budget_left    <= budget_d;
			res.tripped        <= limit_d;
			res.save_request   <= save_d;
		end
	end
endmodule

// ----- verif/tb_stepper_command_travel_limit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stepper_command_travel_limit
// Drives speed, turn, poll and stop requests with random gaps and result
// stalls. A built-in predictor of the command block works out each expected
// result, and the results are checked field by field in order.
// ----------------------------------------------------------------------------
module tb_stepper_command_travel_limit;
	import stc_pkg::*;

	typedef struct packed {
		logic [15:0] step_compare;
		logic        step_active;
		logic        direction_cw;
		logic        driver_enable;
		logic [15:0] target_compare;
		logic        counter_clear;
		logic [30:0] budget_left;
		logic        tripped;
		logic        save_request;
	} motor_res_t;

	localparam int unsigned LIMIT_CYCLES = 2000000;

	logic clk;
	logic arst_n;
	stc_cmd_if cmd ();
	stc_res_if res ();
	stc_cfg_if cfg ();

	stepper_command_travel_limit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res),
		.cfg    (cfg)
	);

	// predictor state
	logic [15:0] mstep;
	logic        m_dir;
	logic        m_run;
	logic        m_pulse;
	logic [15:0] m_cmp;
	logic [15:0] m_tgt;
	logic [15:0] m_prev;
	longint      m_budget;
	logic        m_trip;
	longint      m_saved;
	logic        m_zsaved;

	motor_res_t expected_q[$];
	int unsigned errors;
	int unsigned cycles;
	int unsigned burst_left;
	bit          stall_en;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic model_reset();
		mstep = MSTEP_RST;
		m_dir = 0; m_run = 0; m_pulse = 0; m_cmp = 0; m_tgt = 0; m_prev = 0;
		m_budget = 30000; m_saved = 30000; m_trip = 0; m_zsaved = 0;
	endtask

	task automatic model_halt();
		m_pulse = 0; m_cmp = 0; m_tgt = 0; m_run = 0; m_prev = 0; m_dir = 0;
	endtask

	task automatic model_speed(input logic [15:0] rbits);
		longint r;
		longint unsigned c;
		longint unsigned f;
		longint unsigned q;
		r = $signed(rbits);
		if (r > 0) m_dir = 1;
		else if (r < 0) m_dir = 0;
		if (r < 0) r = -r;
		if (r == 0) begin
			m_pulse = 0;
			m_cmp = 0;
			return;
		end
		c = (r > 1000) ? 1000 : r;
		f = c * mstep / 60;
		if (f == 0) begin
			m_cmp = 16'hFFFF;
		end else begin
			q = 64'(CLOCK_HZ) / (2 * 64'(PRESCALE) * f);
			m_cmp = (q == 0 || q - 1 > 65535) ? 16'hFFFF : 16'(q - 1);
		end
		m_pulse = 1;
		if (!m_run && !m_trip) m_run = 1;
	endtask

	// predicted result of one command request
	task automatic predict_command(input kind_t k, input logic [15:0] rbits,
			input logic [31:0] ang, input logic [15:0] smp);
		motor_res_t e;
		logic clr;
		logic sv;
		longint unsigned mag;
		longint unsigned cnt;
		clr = 0;
		sv = 0;
		case (k)
			KIND_SPEED: model_speed(rbits);
			KIND_TURN: begin
				if (ang[31]) begin
					mag = 64'(32'(-ang));
					if (mag == 0) mag = 64'h8000_0000;
					rbits = -rbits;
				end else begin
					mag = ang;
				end
				cnt = mag * mstep / 360;
				if (cnt > 65536) cnt = 65536;
				m_tgt = 16'(cnt - 1);
				clr = 1;
				model_speed(rbits);
			end
			KIND_POLL: begin
				if (m_budget > 0 || !m_dir) begin
					if (m_dir) m_budget -= longint'(16'(smp - m_prev));
					else m_budget += longint'(16'(smp - m_prev));
					m_prev = smp;
					if (m_budget > 2147483647) m_budget = 2147483647;
					m_trip = 0;
				end
				if (m_budget <= 0) begin
					model_halt();
					clr = 1;
					m_budget = 0;
					m_trip = 1;
				end
				if (m_budget - m_saved > 500 || m_saved - m_budget > 500) begin
					sv = 1;
					m_saved = m_budget;
				end else if (m_budget == 0 && !m_zsaved) begin
					sv = 1;
					m_saved = 0;
					m_zsaved = 1;
				end
			end
			default: begin
				model_halt();
				clr = 1;
			end
		endcase
		e.step_compare = m_cmp;
		e.step_active = m_pulse;
		e.direction_cw = m_dir;
		e.driver_enable = m_run;
		e.target_compare = m_tgt;
		e.counter_clear = clr;
		e.budget_left = 31'(m_budget);
		e.tripped = m_trip;
		e.save_request = sv;
		expected_q.push_back(e);
	endtask

	// send one command request, in bursts with random gaps
	task automatic send_command(input kind_t k, input logic [15:0] rbits,
			input logic [31:0] ang, input logic [15:0] smp);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				cmd.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		cmd.valid <= 1'b1;
		cmd.kind <= k;
		cmd.rpm <= rbits;
		cmd.angle_deg <= ang;
		cmd.count_sample <= smp;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		predict_command(k, rbits, ang, smp);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		cmd.valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic write_register(input cfg_idx_t idx, input logic [15:0] val);
		wait_drained();
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		if (idx == CFG_MICROSTEPS) begin
			mstep = val;
		end else begin
			m_budget = longint'(val);
			m_saved = longint'(val);
		end
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// result check
	always @(posedge clk) begin
		motor_res_t got;
		motor_res_t e;
		if (res.valid && res.ready) begin
			got = {res.step_compare, res.step_active, res.direction_cw, res.driver_enable,
				res.target_compare, res.counter_clear, res.budget_left, res.tripped,
				res.save_request};
			if (expected_q.size() == 0) begin
				$error("result with no request pending");
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (got.step_compare !== e.step_compare) begin
					$error("step_compare exp %0d got %0d", e.step_compare, got.step_compare);
					errors++;
				end
				if (got.step_active !== e.step_active) begin
					$error("step_active exp %0d got %0d", e.step_active, got.step_active);
					errors++;
				end
				if (got.direction_cw !== e.direction_cw) begin
					$error("direction_cw exp %0d got %0d", e.direction_cw, got.direction_cw);
					errors++;
				end
				if (got.driver_enable !== e.driver_enable) begin
					$error("driver_enable exp %0d got %0d", e.driver_enable,
						got.driver_enable);
					errors++;
				end
				if (got.target_compare !== e.target_compare) begin
					$error("target_compare exp %0d got %0d", e.target_compare,
						got.target_compare);
					errors++;
				end
				if (got.counter_clear !== e.counter_clear) begin
					$error("counter_clear exp %0d got %0d", e.counter_clear,
						got.counter_clear);
					errors++;
				end
				if (got.budget_left !== e.budget_left) begin
					$error("budget_left exp %0d got %0d", e.budget_left, got.budget_left);
					errors++;
				end
				if (got.tripped !== e.tripped) begin
					$error("tripped exp %0d got %0d", e.tripped, got.tripped);
					errors++;
				end
				if (got.save_request !== e.save_request) begin
					$error("save_request exp %0d got %0d", e.save_request,
						got.save_request);
					errors++;
				end
			end
		end
	end

	// receiver stall pattern
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_en <= ~stall_en;
		res.ready <= stall_en ? ($urandom_range(0, 3) != 0) : 1'b1;
	end

	function automatic logic [15:0] rand_rpm();
		case ($urandom_range(0, 4))
			0: return 16'($urandom);
			1: return 16'(-$signed(16'($urandom_range(0, 1100))));
			default: return 16'($urandom_range(0, 1100));
		endcase
	endfunction

	function automatic logic [31:0] rand_angle();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return -$urandom_range(0, 4000);
			default: return $urandom_range(0, 4000);
		endcase
	endfunction

	task automatic test_directed();
		send_command(KIND_SPEED, 16'sd1000, 0, 0);
		send_command(KIND_SPEED, 16'sd1, 0, 0);
		send_command(KIND_SPEED, 16'h8000, 0, 0);
		send_command(KIND_SPEED, 16'sd0, 0, 0);
		send_command(KIND_SPEED, 16'h7FFF, 0, 0);
		send_command(KIND_TURN, 16'sd300, 32'd0, 0);
		send_command(KIND_TURN, 16'sd300, 32'h8000_0000, 0);
		send_command(KIND_TURN, 16'hFFFF, 32'h7FFF_FFFF, 0);
		send_command(KIND_TURN, 16'sd50, -32'sd90, 0);
		send_command(KIND_POLL, 0, 0, 16'hFFFF);
		send_command(KIND_SPEED, 16'sd600, 0, 0);
		send_command(KIND_POLL, 0, 0, 16'd0);
		send_command(KIND_POLL, 0, 0, 16'd100);
		send_command(KIND_STOP, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
	endtask

	// small budget so clockwise polls trip the limit
	task automatic test_trip();
		write_register(CFG_BUDGET, 16'd700);
		send_command(KIND_SPEED, 16'sd200, 0, 0);
		send_command(KIND_POLL, 0, 0, 16'd300);
		send_command(KIND_POLL, 0, 0, 16'd900);
		send_command(KIND_POLL, 0, 0, 16'd950);
		send_command(KIND_SPEED, 16'sd200, 0, 0);
		send_command(KIND_SPEED, -16'sd200, 0, 0);
		send_command(KIND_POLL, 0, 0, 16'd2000);
		send_command(KIND_SPEED, 16'sd10, 0, 0);
	endtask

	task automatic test_random(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 9);
			if (r < 3) send_command(KIND_SPEED, rand_rpm(), $urandom, 16'($urandom));
			else if (r < 5)
				send_command(KIND_TURN, rand_rpm(), rand_angle(), 16'($urandom));
			else if (r < 9)
				send_command(KIND_POLL, 16'($urandom), $urandom,
					($urandom_range(0, 7) == 0) ? 16'($urandom)
					: m_prev + 16'($urandom_range(0, 600)));
			else send_command(KIND_STOP, 16'($urandom), $urandom, 16'($urandom));
		end
	endtask

	task automatic test_config_sweep();
		write_register(CFG_MICROSTEPS, 16'd1);
		write_register(CFG_BUDGET, 16'd0);
		test_random(250);
		write_register(CFG_MICROSTEPS, 16'hFFFF);
		write_register(CFG_BUDGET, 16'hFFFF);
		test_random(250);
		write_register(CFG_MICROSTEPS, 16'd59);
		write_register(CFG_BUDGET, 16'd2000);
		test_random(250);
		write_register(CFG_MICROSTEPS, 16'($urandom_range(1, 65535)));
		write_register(CFG_BUDGET, 16'($urandom));
		test_random(250);
		write_register(CFG_MICROSTEPS, 16'd200);
		test_random(250);
	endtask

	initial begin
		burst_left = 0;
		cmd.valid = 1'b0;
		cmd.kind = KIND_SPEED;
		cmd.rpm = '0;
		cmd.angle_deg = '0;
		cmd.count_sample = '0;
		cfg.valid = 1'b0;
		cfg.index = CFG_MICROSTEPS;
		cfg.data = '0;
		model_reset();
		arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_trip();
		test_random(250);
		test_config_sweep();
		wait_drained();
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
